// File: sv/rxs_pkg.sv
// Shared types, constants and helpers for the record exchange sort block.
// Used by the channel interfaces, the output stage and the top level.
// No dependencies.
package rxs_pkg;

  // Store geometry
  localparam int MAX_RECORDS   = 16;
  localparam int IDX_W         = $clog2(MAX_RECORDS);
  localparam int CNT_W         = IDX_W + 1;
  localparam int SUBJECT_COUNT = 7;

  // Field widths
  localparam int ID_W    = 8;
  localparam int SCORE_W = 10;
  localparam int KEY_W   = 13;

  // Divide by seven as multiply by reciprocal: floor(x * 9363 / 2^16) is exact
  // for every x below 13107, which covers the whole key range.
  localparam int           DIV7_SHIFT = 16;
  localparam int           DIV7_MUL_W = 14;
  localparam logic [DIV7_MUL_W-1:0] DIV7_MUL = 14'd9363;

  // One stored record: identifier and score sum
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
  } entry_t;

  // Load request from the sequencer to the output stage
  typedef struct packed {
    logic             load;
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
    logic             dropped;
    logic             last;
  } emit_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RD_I,
    ST_LD_I,
    ST_CMP,
    ST_WB,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_HOLD
  } state_e;

  function automatic logic [SCORE_W-1:0] div7(input logic [KEY_W-1:0] key);
    logic [KEY_W+DIV7_MUL_W-1:0] prod;
    prod = (KEY_W+DIV7_MUL_W)'(key) * (KEY_W+DIV7_MUL_W)'(DIV7_MUL);
    return SCORE_W'(prod >> DIV7_SHIFT);
  endfunction

endpackage

// File: sv/rxs_if.sv
// Valid/ready channel interfaces for record input items and result items.
// Depends on rxs_pkg for field widths.
interface rxs_in_if import rxs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ID_W-1:0]    record_id;
  logic [SCORE_W-1:0] score_math;
  logic [SCORE_W-1:0] score_physics;
  logic [SCORE_W-1:0] score_chemistry;
  logic [SCORE_W-1:0] score_biology;
  logic [SCORE_W-1:0] score_literature;
  logic [SCORE_W-1:0] score_history;
  logic [SCORE_W-1:0] score_geography;
  logic               last_in;

  modport source (
    output valid, record_id, score_math, score_physics, score_chemistry,
           score_biology, score_literature, score_history, score_geography,
           last_in,
    input  ready
  );
  modport sink (
    input  valid, record_id, score_math, score_physics, score_chemistry,
           score_biology, score_literature, score_history, score_geography,
           last_in,
    output ready
  );
endinterface

interface rxs_out_if import rxs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ID_W-1:0]    out_id;
  logic [KEY_W-1:0]   score_sum;
  logic [SCORE_W-1:0] average_hundredths;
  logic               dropped_any;
  logic               last_out;

  modport source (
    output valid, out_id, score_sum, average_hundredths, dropped_any, last_out,
    input  ready
  );
  modport sink (
    input  valid, out_id, score_sum, average_hundredths, dropped_any, last_out,
    output ready
  );
endinterface

// File: sv/rxs_out_stage.sv
// Result output register: holds one result item until the sink takes it and
// computes the truncated average. Depends on rxs_pkg and rxs_out_if.
module rxs_out_stage import rxs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  emit_t            emit_i,
  output logic             taken_o,
  rxs_out_if.source        out_o
);

  logic               valid_q;
  logic [ID_W-1:0]    id_q;
  logic [KEY_W-1:0]   sum_q;
  logic [SCORE_W-1:0] avg_q;
  logic               dropped_q;
  logic               last_q;

  assign taken_o = valid_q && out_o.ready;

  // Valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (emit_i.load) begin
      valid_q <= 1'b1;
    end else if (taken_o) begin
      valid_q <= 1'b0;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (emit_i.load) begin
      id_q      <= emit_i.id;
      sum_q     <= emit_i.key;
      avg_q     <= div7(emit_i.key);
      dropped_q <= emit_i.dropped;
      last_q    <= emit_i.last;
    end
  end

  assign out_o.valid              = valid_q;
  assign out_o.out_id             = id_q;
  assign out_o.score_sum          = sum_q;
  assign out_o.average_hundredths = avg_q;
  assign out_o.dropped_any        = dropped_q;
  assign out_o.last_out           = last_q;

endmodule

// File: sv/record_exchange_sort_by_score_sum.sv
// Record exchange sort by score sum. Records are taken one per cycle while
// loading; each stores its identifier and the sum of its seven scores in a
// 16-entry single-write, single-read memory with a registered read. A record
// marked last starts a descending exchange sort over the n stored records,
// during which no input is accepted: for each i a pass keeps entry i in a
// register and walks j one entry a cycle, its pace bound by the single memory
// read port. Results then leave in sorted order, one at a time, each through
// read, register and handoff, and held longer if the sink stalls. Records
// beyond 16 are dropped and reported in dropped_any of every result of that
// set. Depends on rxs_pkg, rxs_if and rxs_out_stage.
module record_exchange_sort_by_score_sum import rxs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  rxs_in_if.sink    in_i,
  rxs_out_if.source out_o
);

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               ovf_q, ovf_d;
  logic [IDX_W-1:0]   i_q, i_d, j_q, j_d, k_q, k_d;
  entry_t             cur_q, cur_d;

  entry_t             mem [MAX_RECORDS];
  entry_t             rd_q;
  logic               we;
  logic [IDX_W-1:0]   waddr, raddr;
  entry_t             wdata;

  logic               in_ready, in_acc;
  logic [KEY_W-1:0]   sum;
  logic [CNT_W-1:0]   cnt_inc, load_n;
  logic               full, swap, j_more, i_more, k_last;
  emit_t              emit;
  logic               taken;

  // Score sum of the incoming record
  assign sum = KEY_W'(in_i.score_math) + KEY_W'(in_i.score_physics)
             + KEY_W'(in_i.score_chemistry) + KEY_W'(in_i.score_biology)
             + KEY_W'(in_i.score_literature) + KEY_W'(in_i.score_history)
             + KEY_W'(in_i.score_geography);

  assign in_i.ready = in_ready;
  assign in_acc     = in_i.valid && in_ready;

  // Loop bounds and compare
  assign full    = count_q == CNT_W'(MAX_RECORDS);
  assign cnt_inc = count_q + CNT_W'(1);
  assign load_n  = full ? count_q : cnt_inc;
  assign j_more  = ({1'b0, j_q} + CNT_W'(1)) < count_q;
  assign i_more  = ({1'b0, i_q} + CNT_W'(2)) < count_q;
  assign k_last  = ({1'b0, k_q} + CNT_W'(1)) == count_q;
  assign swap    = cur_q.key < rd_q.key;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_acc && in_i.last_in) begin
          state_d = (load_n > CNT_W'(1)) ? ST_RD_I : ST_EMIT_RD;
        end
      end
      ST_RD_I:    state_d = ST_LD_I;
      ST_LD_I:    state_d = ST_CMP;
      ST_CMP: begin
        if (!j_more) begin
          state_d = ST_WB;
        end
      end
      ST_WB:      state_d = i_more ? ST_RD_I : ST_EMIT_RD;
      ST_EMIT_RD: state_d = ST_EMIT_LD;
      ST_EMIT_LD: state_d = ST_EMIT_HOLD;
      ST_EMIT_HOLD: begin
        if (taken) begin
          state_d = k_last ? ST_LOAD : ST_EMIT_RD;
        end
      end
      default:    state_d = ST_LOAD;
    endcase
  end

  // Outputs: memory access, counters, emit strobe
  always_comb begin
    in_ready     = 1'b0;
    we           = 1'b0;
    waddr        = i_q;
    wdata        = cur_q;
    raddr        = i_q;
    count_d      = count_q;
    ovf_d        = ovf_q;
    i_d          = i_q;
    j_d          = j_q;
    k_d          = k_q;
    cur_d        = cur_q;
    emit.load    = 1'b0;
    emit.id      = rd_q.id;
    emit.key     = rd_q.key;
    emit.dropped = ovf_q;
    emit.last    = k_last;
    unique case (state_q)
      ST_LOAD: begin
        in_ready = 1'b1;
        i_d      = '0;
        k_d      = '0;
        if (in_acc) begin
          if (!full) begin
            we       = 1'b1;
            waddr    = count_q[IDX_W-1:0];
            wdata.id = in_i.record_id;
            wdata.key = sum;
            count_d  = cnt_inc;
          end else begin
            ovf_d = 1'b1;
          end
        end
      end
      ST_RD_I: begin
        raddr = i_q;
      end
      ST_LD_I: begin
        // entry i goes to the register, start reading j = i + 1
        cur_d = rd_q;
        raddr = i_q + IDX_W'(1);
        j_d   = i_q + IDX_W'(1);
      end
      ST_CMP: begin
        // swap: old holder goes to j, entry j becomes the holder
        if (swap) begin
          we    = 1'b1;
          waddr = j_q;
          wdata = cur_q;
          cur_d = rd_q;
        end
        raddr = j_q + IDX_W'(1);
        j_d   = j_q + IDX_W'(1);
      end
      ST_WB: begin
        we    = 1'b1;
        waddr = i_q;
        wdata = cur_q;
        i_d   = i_q + IDX_W'(1);
        k_d   = '0;
      end
      ST_EMIT_RD: begin
        raddr = k_q;
      end
      ST_EMIT_LD: begin
        emit.load = 1'b1;
      end
      ST_EMIT_HOLD: begin
        if (taken) begin
          if (k_last) begin
            count_d = '0;
            ovf_d   = 1'b0;
          end else begin
            k_d = k_q + IDX_W'(1);
          end
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      count_q <= '0;
      ovf_q   <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  // Holder register for entry i
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  // Record store: one write, one registered read per cycle; in load and write-back
  // the read address can equal the write address, but that read data goes unused
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  rxs_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .emit_i  (emit),
    .taken_o (taken),
    .out_o   (out_o)
  );

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_RECORDS))
    else $error("record count above capacity");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> full)
    else $error("drop flag set with room in the store");

  a_last_leaves_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.last_in |=> state_q != ST_LOAD)
    else $error("last record did not start the sort");

  a_no_result_in_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LOAD |-> !out_o.valid)
    else $error("result pending while loading");

  a_j_after_i: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CMP |-> j_q > i_q)
    else $error("inner index not past outer index");
`endif

endmodule
